[rtl/bse_pkg.sv]
// ---------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bitmap to sixel band encoder.
// ---------------------------------------------------------------------------
package bse_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int LINE_WIDTH_W = 11;
   localparam int IMAGE_ROWS_W = 16;
   localparam int CSR_DATA_W   = 16;

   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;
   localparam logic [IMAGE_ROWS_W-1:0] IMAGE_ROWS_RESET = 16'd480;

   // Register indexes
   localparam logic CSR_LINE_WIDTH = 1'b0;
   localparam logic CSR_IMAGE_ROWS = 1'b1;

   localparam int          SIXEL_W      = 6;
   localparam logic [2:0]  BAND_LAST    = 3'd5;     // sixth row of a band
   localparam logic [7:0]  SIXEL_OFFSET = 8'd63;
   localparam logic [7:0]  BAND_NEWLINE = 8'd45;   // '-'

   typedef struct packed {
      logic [7:0] code_byte;
      logic       band_end;
      logic       image_end;
   } result_type;

   // Up to two results written into the output queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

[rtl/bse_ram.sv]
// ---------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bse_outq.sv]
// ---------------------------------------------------------------------------
// bse_outq
// Four-entry result queue; takes up to two results a cycle, gives one.
// ---------------------------------------------------------------------------
module bse_outq (
   input  logic                clock,
   input  logic                reset,
   input  bse_pkg::push_type   push,
   output logic                room2,      // at least two entries free
   output logic                out_valid,
   input  logic                out_ready,
   output bse_pkg::result_type out_item
);
   import bse_pkg::*;

   result_type  slot_ff [4];
   logic [1:0]  head_ff, head_in;
   logic [1:0]  tail_ff, tail_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = slot_ff[head_ff];
   assign room2     = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff + {1'b0, pop};
      tail_in  = tail_ff + push.count;
      count_in = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[tail_ff + 2'd1] <= push.second;
      end
   end

endmodule

[rtl/bitmap_to_sixel_encoder.sv]
// ---------------------------------------------------------------------------
// bitmap_to_sixel_encoder
// Packs a one-bit raster into sixel bands using a column line store.
// ---------------------------------------------------------------------------
// Throughput: one pixel per cycle while the output queue has room for two;
//   the newline after a finished band row is one extra output byte, absorbed
//   by the four-entry output queue unless band rows end back to back, when
//   requests stall. A sixel byte passes stage 1, then the output queue.
// Reset: synchronous; counters clear, line_width = 640, image_rows = 480.
//   The band store needs no clearing pass: each band's first row overwrites.
// ---------------------------------------------------------------------------
module bitmap_to_sixel_encoder #(
   parameter int MAX_WIDTH = bse_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // pixel requests
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] pixel, [7:1] zero
   // encoded bytes
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] code_byte
   output logic                           rsp_tlast,   // band_end
   output logic                           rsp_tuser,   // [0] image_end
   // configuration writes
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [bse_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bse_pkg::*;

   // Column index bits and bits needed to hold the width itself
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int XW = (WB > LINE_WIDTH_W) ? WB : LINE_WIDTH_W;

   // ---- configuration registers ------------------------------------------
   logic [LINE_WIDTH_W-1:0] line_width_ff;
   logic [IMAGE_ROWS_W-1:0] image_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         image_rows_ff <= IMAGE_ROWS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata[LINE_WIDTH_W-1:0];
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata[IMAGE_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective width: zero acts as one, clipped to the store depth
   logic [XW-1:0]           lw_x;
   logic [WB-1:0]           width_eff;
   logic [CW-1:0]           last_col_idx;
   logic [IMAGE_ROWS_W-1:0] rows_m1;

   always_comb begin
      lw_x = XW'(line_width_ff);
      if (lw_x == '0) begin
         width_eff = WB'(1);
      end else if (lw_x > XW'(MAX_WIDTH)) begin
         width_eff = WB'(MAX_WIDTH);
      end else begin
         width_eff = lw_x[WB-1:0];
      end
      last_col_idx = CW'(width_eff - WB'(1));
      rows_m1 = (image_rows_ff == '0) ? '0 : image_rows_ff - 16'd1;
   end

   // ---- stage 0: position counters, store read --------------------------
   logic [CW-1:0]           col_ff, col_in;
   logic [2:0]              rib_ff, rib_in;
   logic [IMAGE_ROWS_W-1:0] row_ff, row_in;

   logic [CW-1:0] col_c;
   logic [2:0]    rib_c;
   logic          last_col, last_row, band_done;
   logic          req_fire;

   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      // Registers may shrink mid-image: clamp the position
      col_c     = (col_ff > last_col_idx) ? last_col_idx : col_ff;
      rib_c     = (rib_ff > BAND_LAST) ? BAND_LAST : rib_ff;
      last_col  = (col_c == last_col_idx);
      last_row  = (row_ff >= rows_m1);
      band_done = (rib_c == BAND_LAST) || last_row;

      col_in = col_ff;
      rib_in = rib_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               rib_in = '0;
               row_in = '0;
            end else begin
               rib_in = band_done ? 3'd0 : rib_c + 3'd1;
               row_in = row_ff + 16'd1;
            end
         end else begin
            col_in = col_c + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         rib_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         rib_ff <= rib_in;
         row_ff <= row_in;
      end
   end

   // ---- stage 1: merge bit into column value, write back, emit ----------
   logic          s1_valid_ff;
   logic          s1_bit_ff;
   logic [2:0]    s1_rib_ff;
   logic [CW-1:0] s1_idx_ff;
   logic          s1_last_col_ff;
   logic          s1_last_row_ff;
   logic          s1_band_done_ff;
   logic          fwd_ff;               // store read raced with a write-back
   logic [SIXEL_W-1:0] fwd_data_ff;

   logic [SIXEL_W-1:0] ram_rd;
   logic [SIXEL_W-1:0] old_bits;
   logic [SIXEL_W-1:0] new_bits;
   logic               room2;
   logic               s1_fire;
   push_type           push;
   result_type         out_item;

   assign s1_fire    = s1_valid_ff && room2;
   assign req_tready = !s1_valid_ff || s1_fire;

   always_comb begin
      old_bits = fwd_ff ? fwd_data_ff : ram_rd;
      if (s1_rib_ff == 3'd0) begin
         new_bits = SIXEL_W'(s1_bit_ff);
      end else begin
         new_bits = old_bits | (SIXEL_W'(s1_bit_ff) << s1_rib_ff);
      end

      push.first.code_byte  = 8'(new_bits) + SIXEL_OFFSET;
      push.first.band_end   = 1'b0;
      push.first.image_end  = 1'b0;
      push.second.code_byte = BAND_NEWLINE;
      push.second.band_end  = 1'b1;
      push.second.image_end = s1_last_row_ff;
      if (s1_fire && s1_band_done_ff) begin
         push.count = s1_last_col_ff ? 2'd2 : 2'd1;
      end else begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            // width of one: next pixel reads the column being written now
            fwd_ff      <= s1_fire && (s1_idx_ff == col_c);
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_bit_ff       <= req_tdata[0];
         s1_rib_ff       <= rib_c;
         s1_idx_ff       <= col_c;
         s1_last_col_ff  <= last_col;
         s1_last_row_ff  <= last_row;
         s1_band_done_ff <= band_done;
         fwd_data_ff     <= new_bits;
      end
   end

   bse_ram #(
      .WIDTH (SIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_band_store (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_idx_ff),
      .wr_data (new_bits),
      .rd_en   (req_fire),
      .rd_addr (col_c),
      .rd_data (ram_rd)
   );

   // ---- output queue -----------------------------------------------------
   bse_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room2     (room2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.code_byte;
   assign rsp_tlast = out_item.band_end;
   assign rsp_tuser = out_item.image_end;

endmodule

[rtl/bse_checker.sv]
// ---------------------------------------------------------------------------
// bse_checker
// Port-level checks on the encoded byte stream.
// ---------------------------------------------------------------------------
module bse_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);
   import bse_pkg::*;

   // Band newline always carries '-'
   a_newline_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == BAND_NEWLINE)
      else $error("band end without newline byte");

   // Image end only on a band newline
   a_image_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("image end outside a band newline");

   // Sixel bytes stay in the printable sixel range
   a_sixel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata >= 8'd63) && (rsp_tdata <= 8'd126))
      else $error("sixel byte out of range");

   // Stalled byte is held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled byte changed");

   // Nothing offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind bitmap_to_sixel_encoder bse_checker u_bse_checker (.*);

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap to sixel band encoder: streams pixel
// requests under several register settings and compares each encoded byte
// with an in-bench prediction of the band store and raster counters.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bse_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int RANDOM_PIXELS = 300;
   localparam int SETTLE_CYCLES = 6;     // extra wait in settle() once no byte is pending
   localparam int IDLE_PCT      = 27;

   // ------------------------------------------------------------------------
   // Band encoder prediction and byte scoreboard
   // ------------------------------------------------------------------------
   class sixel_checker;
      logic [LINE_WIDTH_W-1:0] line_w;
      logic [IMAGE_ROWS_W-1:0] image_h;
      logic [SIXEL_W-1:0]      column_bits [MAX_WIDTH_DEFAULT];
      bit                      written     [MAX_WIDTH_DEFAULT];
      logic [9:0]              col;
      logic [2:0]              band_row;
      logic [15:0]             row_idx;
      result_type              pending_bytes [$];
      int                      errors;

      function new();
         line_w   = LINE_WIDTH_RESET;
         image_h  = IMAGE_ROWS_RESET;
         col      = '0;
         band_row = '0;
         row_idx  = '0;
         errors   = 0;
         foreach (written[i]) begin
            written[i]     = 1'b0;
            column_bits[i] = '0;
         end
      endfunction

      function int unsigned width_now();
         int unsigned w;
         w = line_w;
         if (w == 0) w = 1;
         if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
         return w;
      endfunction

      function int unsigned rows_now();
         return (image_h == 0) ? 1 : image_h;
      endfunction

      // pixels still needed to close the current row
      function int unsigned row_left();
         int unsigned w;
         int unsigned c;
         w = width_now();
         c = col;
         if (c >= w) c = w - 1;
         return w - c;
      endfunction

      // mid-band, a wider row reads columns not written in this band's first row;
      // only allow it where every such column holds something written before
      function bit widen_ok(int unsigned w);
         if (band_row == 0) return 1'b1;
         for (int i = 0; i < w; i++)
            if (!written[i]) return 1'b0;
         return 1'b1;
      endfunction

      function void write_reg(logic addr, logic [CSR_DATA_W-1:0] data);
         if (addr == CSR_LINE_WIDTH) line_w  = data[LINE_WIDTH_W-1:0];
         else                        image_h = data[IMAGE_ROWS_W-1:0];
      endfunction

      function void take_pixel(bit p);
         int unsigned w;
         int unsigned rows;
         int unsigned c;
         logic [SIXEL_W-1:0] v;
         bit last_col;
         bit last_row;
         bit done;
         result_type r;
         w    = width_now();
         rows = rows_now();
         c    = col;
         if (c >= w) c = w - 1;      // shrunk width: this pixel ends the row
         if (band_row > BAND_LAST) band_row = BAND_LAST;

         if (band_row == 0) v = {5'b0, p};
         else               v = column_bits[c] | ({5'b0, p} << band_row);
         column_bits[c] = v;
         written[c]     = 1'b1;

         last_col = (c == w - 1);
         last_row = (row_idx >= rows - 1);   // also true when rows shrank below us
         done     = (band_row == BAND_LAST) || last_row;

         if (done) begin
            r.code_byte = {2'b0, v} + SIXEL_OFFSET;
            r.band_end  = 1'b0;
            r.image_end = 1'b0;
            pending_bytes.push_back(r);
            if (last_col) begin
               r.code_byte = BAND_NEWLINE;
               r.band_end  = 1'b1;
               r.image_end = last_row;
               pending_bytes.push_back(r);
            end
         end

         if (last_col) begin
            col = '0;
            if (last_row) begin
               band_row = '0;
               row_idx  = '0;
            end else begin
               band_row = done ? 3'd0 : band_row + 3'd1;
               row_idx  = row_idx + 16'd1;
            end
         end else begin
            col = 10'(c + 1);
         end
      endfunction

      function void match_byte(result_type got);
         result_type want;
         if (pending_bytes.size() == 0) begin
            $error("unexpected byte: code_byte %0d band_end %0d image_end %0d",
                   got.code_byte, got.band_end, got.image_end);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         if (got.code_byte !== want.code_byte) begin
            $error("code_byte: expected %0d, got %0d", want.code_byte, got.code_byte);
            errors++;
         end
         if (got.band_end !== want.band_end) begin
            $error("band_end: expected %0d, got %0d", want.band_end, got.band_end);
            errors++;
         end
         if (got.image_end !== want.image_end) begin
            $error("image_end: expected %0d, got %0d", want.image_end, got.image_end);
            errors++;
         end
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Signals
   // ------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;     // [0] pixel, [7:1] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;           // [7:0] code_byte
   logic                  rsp_tlast;           // band_end
   logic                  rsp_tuser;           // [0] image_end
   logic                  csr_we     = 1'b0;
   logic                  csr_addr   = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   bit                    calm = 1'b0;         // no idling on either side while set
   int                    cycle_count = 0;

   sixel_checker board = new();

   bitmap_to_sixel_encoder #(
      .MAX_WIDTH (MAX_WIDTH_DEFAULT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Byte sink: check on each accepted byte, stall at random unless calm
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.match_byte('{rsp_tdata, rsp_tlast, rsp_tuser});
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   // One pixel request; valid stays high afterwards so back-to-back
   // requests need no toggle.
   task automatic send_pixel(input bit p);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, p};
      do @(posedge clock); while (!req_tready);
      board.take_pixel(p);
   endtask

   // density in percent of set dots
   task automatic send_run(input int n, input int density);
      for (int i = 0; i < n; i++)
         send_pixel($urandom_range(99) < density);
   endtask

   // Stop requests, let every predicted byte arrive, then let the pipe empty.
   // Rows that finish no band leave nothing to wait on, hence the extra cycles.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; the trailing cycle keeps consecutive writes apart
   task automatic write_csr(input logic addr, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(addr, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      int sent;
      int w;
      int k;
      int n;
      int r;
      int density;
      int pick;
      logic [CSR_DATA_W-1:0] data;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset rows (480) with a narrow row: one full band, no image end.
      // Column 0 all dots, column 1 none, column 2 alternating.
      write_csr(CSR_LINE_WIDTH, 16'd3);
      for (int row = 0; row < 6; row++)
         for (int c = 0; c < 3; c++)
            send_pixel((c == 0) ? 1'b1 : (c == 1) ? 1'b0 : row[0]);

      // Oversized width clamps to the line store size; zero rows acts as one.
      // Row counter is past the new last row, so this row ends the image.
      // Full-rate stretch: no idling on either side.
      settle();
      write_csr(CSR_LINE_WIDTH, 16'hFFFF);
      write_csr(CSR_IMAGE_ROWS, 16'd0);
      calm = 1'b1;
      send_run(MAX_WIDTH_DEFAULT, 50);
      calm = 1'b0;

      // Zero width acts as one column; rows at maximum.
      settle();
      write_csr(CSR_LINE_WIDTH, 16'd0);
      write_csr(CSR_IMAGE_ROWS, 16'hFFFF);
      repeat (7) send_pixel(1'b1);

      // Rows shrink below the current row mid-band: next row ends the image
      settle();
      write_csr(CSR_IMAGE_ROWS, 16'd3);
      send_pixel(1'b0);

      // Width shrinks below the current column mid-row: next pixel ends the row
      settle();
      write_csr(CSR_LINE_WIDTH, 16'd8);
      write_csr(CSR_IMAGE_ROWS, 16'd2);
      send_run(5, 50);
      settle();
      write_csr(CSR_LINE_WIDTH, 16'd3);
      send_run(4, 50);

      // Random phases: mostly whole rows, some ragged stops that leave the
      // counters mid-row for the next register change. Each register change
      // waits for the output to drain first.
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_PIXELS) begin
         calm = (phase >= 2 && phase < 4);
         if ($urandom_range(99) < 75) begin
            settle();
            pick = $urandom_range(2);
            if (pick != 1) begin
               r = $urandom_range(99);
               w = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 12) : $urandom_range(13, 64);
               data = 16'(w);
               if ($urandom_range(99) < 30) data[15:11] = 5'($urandom);
               if (board.widen_ok((w == 0) ? 1 : w))
                  write_csr(CSR_LINE_WIDTH, data);
            end
            if (pick != 0) begin
               r = $urandom_range(99);
               if (r < 5)       data = 16'd0;
               else if (r < 10) data = 16'hFFFF;
               else if (r < 15) data = 16'($urandom);
               else             data = 16'($urandom_range(1, 13));
               write_csr(CSR_IMAGE_ROWS, data);
            end
         end

         case ($urandom_range(3))
            0:       density = 0;
            1:       density = 100;
            2:       density = 50;
            default: density = $urandom_range(100);
         endcase

         if ($urandom_range(99) < 70) begin
            w = board.width_now();
            k = $urandom_range(1, (150 / w > 1) ? 150 / w : 1);
            n = board.row_left() + (k - 1) * w;
         end else begin
            n = $urandom_range(1, 40);
         end
         send_run(n, density);
         sent  += n;
         phase++;
      end

      calm = 1'b0;
      settle();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
